// ----- rtl/smoothed_l1_norm_accumulator_core_defines.svh -----
// Assertion macros used by the smoothed L1 norm accumulator datapath.
`ifndef SMOOTHED_L1_NORM_ACCUMULATOR_CORE_DEFINES_SVH
`define SMOOTHED_L1_NORM_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/slna_pkg.sv -----
// Types and constants of the smoothed L1 norm accumulator.
package slna_pkg;

    localparam int SCALE_W     = 16;
    localparam int SCALE_SHIFT = 12;
    localparam int SMOOTH_W    = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SCALE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPLEX_MODE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMB,
        ST_SQR,
        ST_RAD,
        ST_ROOT,
        ST_ACC
    } ctrl_state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic mul;
        logic comb;
        logic sqr;
        logic rad;
        logic root;
        logic acc;
    } dp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic final_elem;
        logic root_last;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- rtl/slna_sample_if.sv -----
// Input channel: one element pair of the two vectors per beat.
interface slna_sample_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] first_real;
    logic signed [SAMPLE_WIDTH-1:0] first_imag;
    logic signed [SAMPLE_WIDTH-1:0] second_real;
    logic signed [SAMPLE_WIDTH-1:0] second_imag;
    logic                           final_element;

    modport source (
        output valid, first_real, first_imag, second_real, second_imag, final_element,
        input  ready
    );

    modport sink (
        input  valid, first_real, first_imag, second_real, second_imag, final_element,
        output ready
    );
endinterface

// ----- rtl/slna_result_if.sv -----
// Output channel: one accumulated norm per beat.
interface slna_result_if #(
    parameter int SUM_WIDTH = 40
) ();
    logic                 valid;
    logic                 ready;
    logic [SUM_WIDTH-1:0] norm_sum;
    logic                 overflowed;

    modport source (
        output valid, norm_sum, overflowed,
        input  ready
    );

    modport sink (
        input  valid, norm_sum, overflowed,
        output ready
    );
endinterface

// ----- rtl/slna_ctrl.sv -----
// Sequencer of the accumulator: steps one element through the datapath.
module slna_ctrl
    import slna_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_COMB;
            ST_COMB: state_next = ST_SQR;
            ST_SQR:  state_next = ST_RAD;
            ST_RAD:  state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (status.root_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                // hold the last element until the result register is free
                if (!status.final_elem || !status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load     = status.in_valid;
            end
            ST_MUL:  cmd.mul  = 1'b1;
            ST_COMB: cmd.comb = 1'b1;
            ST_SQR:  cmd.sqr  = 1'b1;
            ST_RAD:  cmd.rad  = 1'b1;
            ST_ROOT: cmd.root = 1'b1;
            ST_ACC:  cmd.acc  = !status.final_elem || !status.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- rtl/slna_datapath.sv -----
// Datapath: scale and combine, squares, digit-serial root, saturating sum.
`include "smoothed_l1_norm_accumulator_core_defines.svh"

module slna_datapath
    import slna_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int SUM_WIDTH    = 40
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] first_real,
    input  logic signed [SAMPLE_WIDTH-1:0] first_imag,
    input  logic signed [SAMPLE_WIDTH-1:0] second_real,
    input  logic signed [SAMPLE_WIDTH-1:0] second_imag,
    input  logic                           final_element,
    input  logic                           in_valid,
    input  logic                           results_ready,
    output logic                           out_valid,
    output logic [SUM_WIDTH-1:0]           norm_sum,
    output logic                           overflowed,
    input  dp_cmd_t                        cmd,
    output dp_status_t                     status
);

    localparam int PROD_W = SAMPLE_WIDTH + SCALE_W;
    localparam int Q_W    = PROD_W - SCALE_SHIFT;
    localparam int C_W    = Q_W + 1;
    localparam int MAG_W  = SAMPLE_WIDTH + 3;
    localparam int MUL_W  = (MAG_W > 32) ? 32 : MAG_W;
    localparam int SQ_W   = 2 * MUL_W;
    localparam int RSUM_W = ((SQ_W > SMOOTH_W) ? SQ_W : SMOOTH_W) + 2;
    localparam int RAD_W  = (RSUM_W > 64) ? 64 : RSUM_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int ACC_W  = ((SUM_WIDTH > ROOT_W) ? SUM_WIDTH : ROOT_W) + 1;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

    // configuration
    logic signed [SCALE_W-1:0] step_scale_reg;
    logic [SMOOTH_W-1:0]       smoothing_reg;
    logic                      complex_mode_reg;

    // element registers
    logic signed [SAMPLE_WIDTH-1:0] x1r_reg, x1i_reg, x2r_reg, x2i_reg;
    logic                           final_reg;
    logic signed [PROD_W-1:0]       pr_reg, pi_reg;
    logic [MAG_W-1:0]               mr_reg, mi_reg;
    logic [SQ_W-1:0]                sqr_reg, sqi_reg;
    logic                           sqr_over_reg, sqi_over_reg;
    logic [RAD_W-1:0]               rad_reg;
    logic [REM_W-1:0]               rem_reg;
    logic [ROOT_W-1:0]              root_reg;
    logic [CNT_W-1:0]               cnt_reg;

    // accumulator and result
    logic [SUM_WIDTH-1:0] running_sum_reg;
    logic                 sat_reg;
    logic                 out_valid_reg;
    logic [SUM_WIDTH-1:0] out_sum_reg;
    logic                 out_ovf_reg;

    // combinational
    logic signed [PROD_W-1:0] pr_next, pi_next;
    logic signed [C_W-1:0]    cr_full, ci_full;
    logic [C_W-1:0]           cr_abs, ci_abs;
    logic [MUL_W-1:0]         mr_lo, mi_lo;
    logic [RSUM_W-1:0]        rad_total;
    logic                     rad_sat;
    logic [REM_W-1:0]         rem_shift, trial;
    logic                     digit;
    logic [ACC_W-1:0]         acc_wide;
    logic                     acc_over;
    logic [SUM_WIDTH-1:0]     sum_new;
    logic                     sat_new;

    always_comb
    begin
        pr_next = step_scale_reg * x2r_reg;
        pi_next = step_scale_reg * x2i_reg;

        // arithmetic shift of the product is its upper bits
        cr_full = C_W'(x1r_reg) + C_W'($signed(pr_reg[PROD_W-1:SCALE_SHIFT]));
        ci_full = C_W'(x1i_reg) + C_W'($signed(pi_reg[PROD_W-1:SCALE_SHIFT]));
        cr_abs  = cr_full[C_W-1] ? C_W'(-cr_full) : C_W'(cr_full);
        ci_abs  = ci_full[C_W-1] ? C_W'(-ci_full) : C_W'(ci_full);

        mr_lo = mr_reg[MUL_W-1:0];
        mi_lo = mi_reg[MUL_W-1:0];

        rad_total = RSUM_W'(sqr_reg) + RSUM_W'(sqi_reg) + RSUM_W'(smoothing_reg);
        rad_sat   = sqr_over_reg || sqi_over_reg || ((rad_total >> RAD_W) != '0);

        // one restoring step: bring down two radicand bits, try (root*4 + 1)
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {root_reg, 2'b01};
        digit     = (rem_shift >= trial);

        acc_wide = ACC_W'(running_sum_reg) + ACC_W'(root_reg);
        acc_over = (acc_wide > ACC_W'(SUM_MAX));
        sum_new  = acc_over ? SUM_MAX : acc_wide[SUM_WIDTH-1:0];
        sat_new  = sat_reg || acc_over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_scale_reg   <= '0;
            smoothing_reg    <= '0;
            complex_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_STEP_SCALE:   step_scale_reg   <= cfg_data[SCALE_W-1:0];
                REG_SMOOTHING:    smoothing_reg    <= cfg_data[SMOOTH_W-1:0];
                REG_COMPLEX_MODE: complex_mode_reg <= cfg_data[0];
                default:          step_scale_reg   <= step_scale_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x1r_reg   <= first_real;
            x2r_reg   <= second_real;
            // real mode: drop the imaginary parts
            x1i_reg   <= complex_mode_reg ? first_imag : '0;
            x2i_reg   <= complex_mode_reg ? second_imag : '0;
            final_reg <= final_element;
        end
        if (cmd.mul)
        begin
            pr_reg <= pr_next;
            pi_reg <= pi_next;
        end
        if (cmd.comb)
        begin
            mr_reg <= cr_abs[MAG_W-1:0];
            mi_reg <= ci_abs[MAG_W-1:0];
        end
        if (cmd.sqr)
        begin
            sqr_reg      <= mr_lo * mr_lo;
            sqi_reg      <= mi_lo * mi_lo;
            sqr_over_reg <= ((mr_reg >> MUL_W) != '0);
            sqi_over_reg <= ((mi_reg >> MUL_W) != '0);
        end
        if (cmd.rad)
        begin
            rad_reg  <= rad_sat ? '1 : rad_total[RAD_W-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.root)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= digit ? REM_W'(rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], digit};
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
        if (cmd.acc && final_reg)
        begin
            out_sum_reg <= sum_new;
            out_ovf_reg <= sat_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            sat_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.acc)
            begin
                if (final_reg)
                begin
                    running_sum_reg <= '0;
                    sat_reg         <= 1'b0;
                end
                else
                begin
                    running_sum_reg <= sum_new;
                    sat_reg         <= sat_new;
                end
            end
            if (cmd.acc && final_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.in_valid   = in_valid;
    assign status.final_elem = final_reg;
    assign status.root_last  = (cnt_reg == CNT_W'(ROOT_W - 1));
    assign status.out_busy   = out_valid_reg && !results_ready;

    assign out_valid  = out_valid_reg;
    assign norm_sum   = out_sum_reg;
    assign overflowed = out_ovf_reg;

    `ASSERT_IMPLY(a_sat_pins_max, clk, rst_n, sat_reg, running_sum_reg == SUM_MAX)
    `ASSERT_NEXT(a_final_clears, clk, rst_n, cmd.acc && final_reg, running_sum_reg == '0 && !sat_reg)
    `ASSERT_IMPLY(a_result_from_acc, clk, rst_n, $rose(out_valid_reg), $past(cmd.acc && final_reg))
    `ASSERT_IMPLY(a_no_overrun, clk, rst_n, cmd.acc && final_reg, !(out_valid_reg && !results_ready))

endmodule

// ----- rtl/smoothed_l1_norm_accumulator_core.sv -----
// Top level of the smoothed L1 norm accumulator: channels, sequencer and datapath.
//
//   channel   dir  payload                                             beat when
//   samples   in   first_real/imag, second_real/imag, final_element    valid & ready
//   results   out  norm_sum, overflowed                                valid & ready
//   cfg       in   cfg_index, cfg_data                                 cfg_wr_en
//
// An element runs through load, multiply, combine, square, radicand, root, accumulate;
// the square root retires one result bit per cycle; ROOT_W is half the radicand width.
// samples.ready is high only between elements; a final element waits in its last
// step while an earlier result still sits unclaimed in the output register.
// Reset clears the configuration, the running sum, its saturation flag and results.valid.
module smoothed_l1_norm_accumulator_core
    import slna_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int SUM_WIDTH    = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    slna_sample_if.sink            samples,
    slna_result_if.source          results,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign samples.ready = cmd.in_ready;

    slna_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    slna_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SUM_WIDTH    (SUM_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .first_real    (samples.first_real),
        .first_imag    (samples.first_imag),
        .second_real   (samples.second_real),
        .second_imag   (samples.second_imag),
        .final_element (samples.final_element),
        .in_valid      (samples.valid),
        .results_ready (results.ready),
        .out_valid     (results.valid),
        .norm_sum      (results.norm_sum),
        .overflowed    (results.overflowed),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
